// File: hw/rtl/prp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prp_pkg
// Shared widths, register indexes, the quarter-wave sine table and the
// lookup helper for the point rotation unit.
// ----------------------------------------------------------------------------
package prp_pkg;

    // coordinate and trig formats
    localparam int COORD_W   = 16;
    localparam int TRIG_FRAC = 14;
    localparam int TRIG_W    = TRIG_FRAC + 2;           // signed, holds +-1.0
    localparam int ANGLE_W   = 9;
    localparam int DIFF_W    = COORD_W + 1;             // point minus pivot
    localparam int PROD_W    = DIFF_W + TRIG_W;
    localparam int ACC_W     = PROD_W + 1;              // sum of two products
    localparam int Q_W       = ACC_W - TRIG_FRAC;       // integer part
    localparam int CFG_W     = (COORD_W > ANGLE_W) ? COORD_W : ANGLE_W;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = 2'd2;

    // angle landmarks in degrees
    localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
    localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
    localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
    localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

    // table build: series evaluation in 64-bit fixed point, done at elaboration
    localparam int          WORK_FRAC     = 30;
    localparam int          ROUND_SHIFT   = WORK_FRAC - TRIG_FRAC;
    localparam int          SINE_ENTRIES  = 91;
    localparam int          SINE_IDX_W    = $clog2(SINE_ENTRIES);
    localparam int          TAYLOR_TERMS  = 10;
    localparam logic [63:0] PI_Q60        = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_STEP       = PI_Q60 / 64'd180;
    localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    typedef logic [SINE_ENTRIES-1:0][TRIG_FRAC:0] sine_table_t;

    // sine and cosine handed from the trig unit to the multiply cells
    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_val;
        logic signed [TRIG_W-1:0] cos_val;
        logic signed [TRIG_W-1:0] nsin_val;   // negated sine for the x lane
    } trig_coef_t;

    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        int          k;
        int          n;
        for (k = 0; k < SINE_ENTRIES; k++)
        begin
            if (k == 0)
            begin
                sum = 64'd0;
            end
            else if (k == SINE_ENTRIES - 1)
            begin
                sum = 64'd1 << WORK_FRAC;
            end
            else
            begin
                x    = (PI_STEP * 64'(k)) >> (60 - WORK_FRAC);
                x2   = (x * x) >> WORK_FRAC;
                sum  = x;
                term = x;
                for (n = 1; n <= TAYLOR_TERMS; n++)
                begin
                    term = ((term * x2) >> WORK_FRAC) / TAYLOR_DIV[n];
                    if ((n % 2) == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
            end
            r      = (sum + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
            tbl[k] = r[TRIG_FRAC:0];
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    // signed sine of an angle in 0..359 degrees
    function automatic logic signed [TRIG_W-1:0] fixed_sine(input logic [ANGLE_W-1:0] a);
        logic                     neg;
        logic [ANGLE_W-1:0]       f;
        logic [TRIG_FRAC:0]       mag;
        logic signed [TRIG_W-1:0] smag;
        neg = (a >= DEG_180);
        f   = neg ? (a - DEG_180) : a;
        if (f > DEG_90)
            f = DEG_180 - f;
        mag  = SINE_TABLE[f[SINE_IDX_W-1:0]];
        smag = signed'(TRIG_W'(mag));
        return neg ? -smag : smag;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/prp_trig.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prp_trig
// Folds the programmed angle into range and holds its sine and cosine.
// ----------------------------------------------------------------------------
module prp_trig (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire logic [prp_pkg::ANGLE_W-1:0]   angle,
    output prp_pkg::trig_coef_t                coef
);
    import prp_pkg::*;

    logic [ANGLE_W-1:0]       angle_mod;
    logic [ANGLE_W-1:0]       cos_angle;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [TRIG_W-1:0] cos_next;
    trig_coef_t               coef_reg;

    always_comb
    begin
        // angles 360..511 wrap once
        angle_mod = (angle >= DEG_360) ? (angle - DEG_360) : angle;
        cos_angle = (angle_mod >= DEG_270) ? (angle_mod - DEG_270) : (angle_mod + DEG_90);
        sin_next  = fixed_sine(angle_mod);
        cos_next  = fixed_sine(cos_angle);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.sin_val  <= '0;
            coef_reg.cos_val  <= signed'(TRIG_W'(1) <<< TRIG_FRAC);
            coef_reg.nsin_val <= '0;
        end
        else if (load)
        begin
            coef_reg.sin_val  <= sin_next;
            coef_reg.cos_val  <= cos_next;
            coef_reg.nsin_val <= -sin_next;
        end
    end

    assign coef = coef_reg;

endmodule
`default_nettype wire

// File: hw/rtl/prp_mac_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prp_mac_cell
// One multiply-accumulate cell: adds operand times coefficient to the
// partial sum from its left neighbor and registers it for the next cell.
// ----------------------------------------------------------------------------
module prp_mac_cell (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [prp_pkg::ACC_W-1:0]   acc_in,
    input  wire logic signed [prp_pkg::DIFF_W-1:0]  mul_a,
    input  wire logic signed [prp_pkg::TRIG_W-1:0]  coef,
    output logic signed [prp_pkg::ACC_W-1:0]        acc_out
);
    import prp_pkg::*;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;

    always_comb
    begin
        prod     = mul_a * coef;
        acc_next = acc_in + ACC_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            acc_reg <= acc_next;
    end

    assign acc_out = acc_reg;

endmodule
`default_nettype wire

// File: hw/rtl/point_rotation_about_pivot_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_rotation_about_pivot_unit
// Rotates 2D points about a programmable pivot by a whole number of degrees,
// with truncation toward zero and saturation to the coordinate width.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload                         dir
//  -------   -------------------   -----------------------------   ---
//  in        in_valid / in_stall   point_x, point_y                in
//  out       out_valid / out_stall rotated_x, rotated_y, overflow  out
//  cfg       cfg_valid / cfg_ready cfg_index, cfg_data             in
//
//  one request per clock when nothing stalls; a result passes five register
//  stages before out_valid rises: capture, two multiply-accumulate cells,
//  truncate and saturate
//  every stage has its own valid bit, so bubbles close up behind a stall
//  reset clears pivot to 0 and angle to 0 degrees (sine 0, cosine 1.0);
//  in_stall is high and cfg_ready low while reset is asserted
//  cfg_ready is high out of reset; a new angle is folded and looked up at the write
//
module point_rotation_about_pivot_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // point requests
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [prp_pkg::COORD_W-1:0]   point_x,
    input  wire logic signed [prp_pkg::COORD_W-1:0]   point_y,
    // rotated results
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [prp_pkg::COORD_W-1:0]        rotated_x,
    output logic signed [prp_pkg::COORD_W-1:0]        rotated_y,
    output logic                                      overflow,
    // register writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [prp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [prp_pkg::CFG_W-1:0]            cfg_data
);
    import prp_pkg::*;

    localparam int SUM_W = Q_W + 1;
    // saturation bounds widened to the pivot-added sum
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        signed'(SUM_W'((64'd1 << (COORD_W - 1)) - 64'd1));
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [COORD_W-1:0] OUT_MAX = SAT_MAX[COORD_W-1:0];
    localparam logic signed [COORD_W-1:0] OUT_MIN = SAT_MIN[COORD_W-1:0];

    // configuration
    logic                      cfg_wr;
    logic                      angle_load;
    logic signed [COORD_W-1:0] pivot_x_reg;
    logic signed [COORD_W-1:0] pivot_y_reg;
    trig_coef_t                coef;

    // per-stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    // stage 1: offsets from the pivot
    logic signed [DIFF_W-1:0]  dx_next, dy_next;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    // stage 2 keeps dy for the second cell
    logic signed [DIFF_W-1:0]  dy2_reg;
    // cell chain partial sums
    logic signed [ACC_W-1:0]   x_acc1, y_acc1, x_acc2, y_acc2;
    // stage 4: integer parts, truncated toward zero
    logic signed [ACC_W-1:0]   x_biased, y_biased;
    logic signed [Q_W-1:0]     qx_next, qy_next;
    logic signed [Q_W-1:0]     qx_reg, qy_reg;
    // stage 5: pivot added back, saturated
    logic signed [SUM_W-1:0]   sx, sy;
    logic signed [COORD_W-1:0] rx_next, ry_next;
    logic                      ovf_x, ovf_y;
    logic signed [COORD_W-1:0] rotated_x_reg, rotated_y_reg;
    logic                      overflow_reg;

    // ------------------------------------------------------------------
    // register writes, ready out of reset; indexes past the list are dropped
    // ------------------------------------------------------------------
    assign cfg_ready  = rst_n;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign angle_load = cfg_wr && (cfg_index == REG_ANGLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == REG_PIVOT_X)
                pivot_x_reg <= signed'(cfg_data[COORD_W-1:0]);
            if (cfg_index == REG_PIVOT_Y)
                pivot_y_reg <= signed'(cfg_data[COORD_W-1:0]);
        end
    end

    prp_trig u_trig (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (angle_load),
        .angle (cfg_data[ANGLE_W-1:0]),
        .coef  (coef)
    );

    // ------------------------------------------------------------------
    // flow control: a stage loads when it is empty or its successor moves
    // ------------------------------------------------------------------
    always_comb
    begin
        en5 = !v5_reg || !out_stall;
        en4 = !v4_reg || en5;
        en3 = !v3_reg || en4;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;
    end

    // no request is taken while reset holds the valid bits clear
    assign in_stall = !en1 || !rst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: move the point into the pivot frame
    // ------------------------------------------------------------------
    always_comb
    begin
        dx_next = DIFF_W'(point_x) - DIFF_W'(pivot_x_reg);
        dy_next = DIFF_W'(point_y) - DIFF_W'(pivot_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (en2)
            dy2_reg <= dy_reg;
    end

    // ------------------------------------------------------------------
    // stages 2 and 3: two chained multiply-accumulate cells per lane
    //   x: dx*cos then + dy*(-sin)
    //   y: dx*sin then + dy*cos
    // ------------------------------------------------------------------
    prp_mac_cell u_x_cell0 (
        .clk     (clk),
        .en      (en2),
        .acc_in  ('0),
        .mul_a   (dx_reg),
        .coef    (coef.cos_val),
        .acc_out (x_acc1)
    );

    prp_mac_cell u_y_cell0 (
        .clk     (clk),
        .en      (en2),
        .acc_in  ('0),
        .mul_a   (dx_reg),
        .coef    (coef.sin_val),
        .acc_out (y_acc1)
    );

    prp_mac_cell u_x_cell1 (
        .clk     (clk),
        .en      (en3),
        .acc_in  (x_acc1),
        .mul_a   (dy2_reg),
        .coef    (coef.nsin_val),
        .acc_out (x_acc2)
    );

    prp_mac_cell u_y_cell1 (
        .clk     (clk),
        .en      (en3),
        .acc_in  (y_acc1),
        .mul_a   (dy2_reg),
        .coef    (coef.cos_val),
        .acc_out (y_acc2)
    );

    // ------------------------------------------------------------------
    // stage 4: drop the fraction, rounding toward zero
    // negative sums get a bias of all-ones fraction before the shift
    // ------------------------------------------------------------------
    always_comb
    begin
        x_biased = x_acc2 + (x_acc2[ACC_W-1] ? ACC_W'((64'd1 << TRIG_FRAC) - 64'd1) : '0);
        y_biased = y_acc2 + (y_acc2[ACC_W-1] ? ACC_W'((64'd1 << TRIG_FRAC) - 64'd1) : '0);
        qx_next  = signed'(x_biased[ACC_W-1:TRIG_FRAC]);
        qy_next  = signed'(y_biased[ACC_W-1:TRIG_FRAC]);
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: add the pivot back and clamp to the coordinate range
    // ------------------------------------------------------------------
    always_comb
    begin
        sx    = SUM_W'(qx_reg) + SUM_W'(pivot_x_reg);
        sy    = SUM_W'(qy_reg) + SUM_W'(pivot_y_reg);
        ovf_x = (sx > SAT_MAX) || (sx < SAT_MIN);
        ovf_y = (sy > SAT_MAX) || (sy < SAT_MIN);
        if (sx > SAT_MAX)
            rx_next = OUT_MAX;
        else if (sx < SAT_MIN)
            rx_next = OUT_MIN;
        else
            rx_next = sx[COORD_W-1:0];
        if (sy > SAT_MAX)
            ry_next = OUT_MAX;
        else if (sy < SAT_MIN)
            ry_next = OUT_MIN;
        else
            ry_next = sy[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            rotated_x_reg <= rx_next;
            rotated_y_reg <= ry_next;
            overflow_reg  <= ovf_x || ovf_y;
        end
    end

    assign out_valid = v5_reg;
    assign rotated_x = rotated_x_reg;
    assign rotated_y = rotated_y_reg;
    assign overflow  = overflow_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // the x lane subtracts exactly the sine the y lane adds
    a_nsin_matches: assert property (@(posedge clk) disable iff (!rst_n)
        coef.nsin_val == -coef.sin_val)
        else $error("negated sine out of step with sine");

    // sine and cosine of a whole degree are never both zero
    a_coef_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !((coef.sin_val == '0) && (coef.cos_val == '0)))
        else $error("sine and cosine both zero");

    // a flagged result has at least one coordinate pinned at a limit
    a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |->
            ((rotated_x == OUT_MAX) || (rotated_x == OUT_MIN) ||
             (rotated_y == OUT_MAX) || (rotated_y == OUT_MIN)))
        else $error("overflow flagged without a saturated coordinate");

    // a request leaving truncation reaches the output register
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && en5) |=> out_valid)
        else $error("request lost between truncate and output stages");

endmodule
`default_nettype wire

// File: bench/rotation_check_pkg.sv
// ----------------------------------------------------------------------------
// rotation_check_pkg
// Scoreboard for the point rotation unit: keeps its own copy of the pivot and
// angle registers and of the sine table, predicts each rotated point and
// checks the results in order.
// ----------------------------------------------------------------------------
package rotation_check_pkg;
    import prp_pkg::*;

    // series evaluation of the sine table, 64-bit fixed point
    localparam int          SERIES_FRAC  = 30;
    localparam int          SERIES_TERMS = 10;
    localparam logic [63:0] PI_Q60_FIX   = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEGREE_Q60   = PI_Q60_FIX / 64'd180;

    localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      ovf;
    } rotated_point_t;

    class rotation_scoreboard;
        logic signed [COORD_W-1:0] pivot_x;
        logic signed [COORD_W-1:0] pivot_y;
        logic [ANGLE_W-1:0]        angle;
        longint                    sine_mag [0:90];
        rotated_point_t            expected_q [$];
        int                        mismatches;

        function new();
            pivot_x    = '0;
            pivot_y    = '0;
            angle      = '0;
            mismatches = 0;
            for (int k = 0; k <= 90; k++)
                sine_mag[k] = longint'((quarter_sine(k)
                    + (64'd1 << (SERIES_FRAC - TRIG_FRAC - 1))) >> (SERIES_FRAC - TRIG_FRAC));
        endfunction

        // sine of 0..90 degrees, unsigned, SERIES_FRAC fraction bits
        function logic [63:0] quarter_sine(int k);
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] sum;
            if (k == 0)
                return 64'd0;
            if (k >= 90)
                return 64'd1 << SERIES_FRAC;
            x    = (DEGREE_Q60 * 64'(k)) >> (60 - SERIES_FRAC);
            x2   = (x * x) >> SERIES_FRAC;
            sum  = x;
            term = x;
            for (int n = 1; n <= SERIES_TERMS; n++)
            begin
                term = ((term * x2) >> SERIES_FRAC) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            return sum;
        endfunction

        // signed Q2.14 sine of 0..359 degrees
        function longint sine_q14(int a);
            int deg;
            bit neg;
            deg = a;
            neg = (deg >= 180);
            if (neg)
                deg = deg - 180;
            if (deg > 90)
                deg = 180 - deg;
            return neg ? -sine_mag[deg] : sine_mag[deg];
        endfunction

        function longint toward_zero(longint v);
            return (v < 0) ? -((-v) >>> TRIG_FRAC) : (v >>> TRIG_FRAC);
        endfunction

        function logic signed [COORD_W-1:0] clamp(longint v);
            if (v > COORD_MAX)
                return COORD_W'(COORD_MAX);
            if (v < COORD_MIN)
                return COORD_W'(COORD_MIN);
            return COORD_W'(v);
        endfunction

        function rotated_point_t rotate(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y);
            rotated_point_t r;
            longint         dx;
            longint         dy;
            longint         s;
            longint         c;
            longint         ax;
            longint         ay;
            int             a;
            a = int'(angle);
            if (a >= int'(DEG_360))
                a = a - int'(DEG_360);
            s  = sine_q14(a);
            c  = sine_q14((a >= 270) ? a - 270 : a + 90);
            dx = longint'(x) - longint'(pivot_x);
            dy = longint'(y) - longint'(pivot_y);
            ax = toward_zero(dx * c - dy * s) + longint'(pivot_x);
            ay = toward_zero(dx * s + dy * c) + longint'(pivot_y);
            r.x   = clamp(ax);
            r.y   = clamp(ay);
            r.ovf = (ax > COORD_MAX) || (ax < COORD_MIN) || (ay > COORD_MAX) || (ay < COORD_MIN);
            return r;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_PIVOT_X: pivot_x = data[COORD_W-1:0];
                REG_PIVOT_Y: pivot_y = data[COORD_W-1:0];
                REG_ANGLE:   angle   = data[ANGLE_W-1:0];
                default: ;
            endcase
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endfunction

        function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
            expected_q.push_back(rotate(x, y));
        endfunction

        function void check_result(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                   logic ovf);
            rotated_point_t e;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result (%0d,%0d) with no request pending", x, y));
                return;
            end
            e = expected_q.pop_front();
            if (x !== e.x)
                report_mismatch($sformatf("rotated_x got %0d expected %0d", x, e.x));
            if (y !== e.y)
                report_mismatch($sformatf("rotated_y got %0d expected %0d", y, e.y));
            if (ovf !== e.ovf)
                report_mismatch($sformatf("overflow got %b expected %b", ovf, e.ovf));
        endfunction
    endclass

endpackage

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for point_rotation_about_pivot_unit. A directed pass covers extreme
// coordinates, the exact axes, saturation and angle wrap, then random points
// run under several pivot and angle settings with random idle cycles on the
// request side and random stalls on the result side. Every result is checked
// against an in-order prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import prp_pkg::*;
    import rotation_check_pkg::*;

    localparam int LATENCY      = 5;
    localparam int LIMIT_CYCLES = 400000;

    // index with no register behind it, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic signed [COORD_W-1:0] point_x   = '0;
    logic signed [COORD_W-1:0] point_y   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic                      overflow;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data  = '0;

    // chance in percent of an idle request cycle and of a stalled result cycle
    int idle_pct  = 0;
    int stall_pct = 0;

    // pivot currently programmed, random points cluster around it
    logic signed [COORD_W-1:0] cur_px = '0;
    logic signed [COORD_W-1:0] cur_py = '0;

    rotation_scoreboard sb = new();

    always #5 clk = ~clk;

    point_rotation_about_pivot_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y),
        .overflow  (overflow),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // result side back-pressure, fresh random draw each cycle
    always @(posedge clk)
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // watch all three channels at the edge, values seen are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_point(point_x, point_y);
            if (out_valid && !out_stall)
                sb.check_result(rotated_x, rotated_y, overflow);
        end
    end

    // present one request and hold it until taken, then maybe go idle a while
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        point_x  <= x;
        point_y  <= y;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop requests and wait until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    // register write; valid stays high across a back-to-back group
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                             input bit last);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // drains the block first, so the registers are written only while it is idle
    task automatic reconfigure(input logic signed [COORD_W-1:0] px,
                               input logic signed [COORD_W-1:0] py,
                               input logic [CFG_W-1:0] angle_data);
        drain();
        cfg_write(REG_PIVOT_X, CFG_W'(px), 1'b0);
        cfg_write(REG_PIVOT_Y, CFG_W'(py), 1'b0);
        cfg_write(REG_ANGLE, angle_data, 1'b1);
        cur_px = px;
        cur_py = py;
    endtask

    // mix of full-range values, extremes and points near the pivot
    function automatic logic signed [COORD_W-1:0] rand_coord(logic signed [COORD_W-1:0] center);
        int sel;
        int span;
        sel = $urandom_range(15);
        if (sel == 0)
            return {1'b0, {(COORD_W-1){1'b1}}};
        if (sel == 1)
            return {1'b1, {(COORD_W-1){1'b0}}};
        if (sel < 8)
            return COORD_W'($urandom);
        span = (sel < 12) ? 255 : 20000;
        return center + COORD_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_pivot();
        case ($urandom_range(7))
            0:       return {1'b0, {(COORD_W-1){1'b1}}};
            1:       return {1'b1, {(COORD_W-1){1'b0}}};
            2:       return '0;
            3, 4:    return COORD_W'(int'($urandom_range(400)) - 200);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic random_config();
        int               ang;
        logic [CFG_W-1:0] ang_data;
        case ($urandom_range(7))
            // out-of-range angle, wraps by one turn
            0: ang = 360 + $urandom_range(151);
            // exact axes and the last degree
            1:
            begin
                case ($urandom_range(4))
                    0:       ang = 0;
                    1:       ang = 90;
                    2:       ang = 180;
                    3:       ang = 270;
                    default: ang = 359;
                endcase
            end
            default: ang = $urandom_range(359);
        endcase
        ang_data = CFG_W'(ang);
        // bits above the angle field are not part of the register
        if ($urandom_range(3) == 0)
            ang_data[CFG_W-1:ANGLE_W] = (CFG_W - ANGLE_W)'($urandom);
        reconfigure(rand_pivot(), rand_pivot(), ang_data);
    endtask

    task automatic send_batch(input int n);
        repeat (n) send_point(rand_coord(cur_px), rand_coord(cur_py));
    endtask

    initial
    begin
        int phase_idle [4];
        int phase_stall [4];
        phase_idle  = '{0, 78, 0, 19};
        phase_stall = '{0, 0, 78, 19};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: angle 0, pivot at origin, point passes straight through
        send_point(16'sd32767, -16'sd32768);
        send_point(-16'sd32768, 16'sd32767);
        send_point(16'sd0, 16'sd0);
        send_point(-16'sd1, 16'sd1);

        // quarter turn, x of the first point goes one past the maximum
        reconfigure(16'sd0, 16'sd0, CFG_W'(90));
        send_point(16'sd32767, -16'sd32768);
        send_point(-16'sd32768, 16'sd0);
        send_point(16'sd100, -16'sd7);

        // half turn about a far corner, differences span the full range
        reconfigure(16'sd32767, -16'sd32768, CFG_W'(180));
        send_point(-16'sd32768, 16'sd32767);
        send_point(16'sd32767, -16'sd32768);

        // three-quarter turn about the opposite corner
        reconfigure(-16'sd32768, 16'sd32767, CFG_W'(270));
        send_point(16'sd32767, -16'sd32768);
        send_point(16'sd5, 16'sd5);

        // irrational trig values, truncation on both signs
        reconfigure(16'sd0, 16'sd0, CFG_W'(45));
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sd12345, -16'sd2345);

        reconfigure(16'sd1000, -16'sd1000, CFG_W'(359));
        send_point(-16'sd1, 16'sd2);
        send_point(16'sd30000, -16'sd30000);

        // all-ones data: angle field 511 wraps to 151
        reconfigure(-16'sd5, 16'sd7, {CFG_W{1'b1}});
        send_point(16'sd20000, -16'sd123);
        send_point(16'sd32767, 16'sd32767);

        // one full turn behaves as zero
        reconfigure(16'sd0, 16'sd0, CFG_W'(360));
        send_point(-16'sd32768, -16'sd32768);

        // write to the unused index, setting must stay as it was
        drain();
        cfg_write(REG_UNUSED, {CFG_W{1'b1}}, 1'b1);
        send_point(16'sd321, -16'sd654);

        reconfigure(16'sd0, 16'sd0, CFG_W'(1));
        send_point(16'sd32767, 16'sd0);

        // random part: quiet, sender gaps, receiver stalls, then both
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            repeat (4)
            begin
                random_config();
                send_batch(46);
            end
        end

        drain();
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hang guard
    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("FAIL");
        $finish;
    end

endmodule
